@@ rtl/core/cpp_pkg.sv @@
package cpp_pkg;

    typedef struct packed {
        logic              operation;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic              closes_path;
        logic [30:0]       query_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } out_item_t;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_PATH = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [1:0] HD_UP    = 2'd0;
    localparam logic [1:0] HD_DOWN  = 2'd1;
    localparam logic [1:0] HD_RIGHT = 2'd2;
    localparam logic [1:0] HD_LEFT  = 2'd3;

    // One stored edge: start point, heading and start time.
    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [1:0]  heading;
        logic [31:0] stime;
    } edge_t;

endpackage

@@ rtl/core/closed_path_position_at_time.sv @@
// A load closing a path of more than one vertex also passes the closing state for the closing
// edge. A query runs the bit-serial modulo, then a binary search whose steps pass the search
// and wait states (synchronous edge memory read), then fetch and output. A zero perimeter
// skips the modulo; a query answered by status alone gives its result in the cycle after it
// is taken. One item is in work at a time; a result waits in an output register and blocks
// new items while stalled. Reset clears the path state; the edge memory is not cleared.
module closed_path_position_at_time #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cpp_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cpp_pkg::out_item_t  out_data
);
    import cpp_pkg::*;

    localparam int AW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_VERTICES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLOSE = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_SRCH  = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     per_reg, per_next;
    logic [31:0]     first_reg, first_next;
    logic [31:0]     prev_reg, prev_next;
    logic            closed_reg, closed_next;
    logic            bad_reg, bad_next;
    logic            started_reg, started_next;
    logic [CW-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [31:0]     t_reg, t_next;
    logic [30:0]     q_reg, q_next;
    logic            ov_reg, ov_next;
    out_item_t       od_reg, od_next;
    logic            div_kick_reg;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    edge_t           wdata, rdata;
    logic            div_start, div_done;
    logic [31:0]     div_rem;

    // Edge builder for one vertex pair.
    logic [15:0]     ep_x, ep_y, eq_x, eq_y;
    logic            e_do;
    logic signed [16:0] dd;
    logic [1:0]      eh;
    logic [31:0]     elen;
    logic            e_diag;
    logic            accept;
    logic [31:0]     diff;
    logic [15:0]     px, py;
    logic [CW-1:0]   span;

    // Path state as seen by the edge stored this cycle.
    logic            ld_started;
    logic [CW-1:0]   ld_cnt;
    logic [31:0]     ld_per;

    cpp_edge_mem #(.AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    cpp_divu u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(q_reg),
        .divisor(per_reg), .done(div_done), .remainder(div_rem)
    );

    assign in_stall = !(state_reg == S_IDLE) || (ov_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        e_diag = 1'b0;
        eh     = HD_DOWN;
        dd     = '0;
        if (ep_x == eq_x)
        begin
            dd = $signed({eq_y[15], eq_y}) - $signed({ep_y[15], ep_y});
            eh = (dd > 0) ? HD_UP : HD_DOWN;
        end
        else if (ep_y == eq_y)
        begin
            dd = $signed({eq_x[15], eq_x}) - $signed({ep_x[15], ep_x});
            eh = (dd > 0) ? HD_RIGHT : HD_LEFT;
        end
        else
            e_diag = 1'b1;
        elen = dd[16] ? 32'(-dd) : 32'(dd);
    end

    always_comb
    begin
        diff = t_reg - rdata.stime;
        px   = rdata.sx;
        py   = rdata.sy;
        unique case (rdata.heading)
            HD_UP:    py = rdata.sy + diff[15:0];
            HD_DOWN:  py = rdata.sy - diff[15:0];
            HD_RIGHT: px = rdata.sx + diff[15:0];
            default:  px = rdata.sx - diff[15:0];
        endcase
    end

    assign span = hi_reg - lo_reg + CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        per_next     = per_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        closed_next  = closed_reg;
        bad_next     = bad_reg;
        started_next = started_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        t_next       = t_reg;
        q_next       = q_reg;
        ov_next      = ov_reg && out_stall;
        od_next      = od_reg;
        ep_x = prev_reg[31:16];
        ep_y = prev_reg[15:0];
        eq_x = in_data.vertex_x;
        eq_y = in_data.vertex_y;
        e_do = 1'b0;
        ld_started = started_reg;
        ld_cnt     = cnt_reg;
        ld_per     = per_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.operation == OP_LOAD)
                begin
                    if (closed_reg)
                    begin
                        ld_cnt = '0; ld_per = '0; bad_next = 1'b0; closed_next = 1'b0;
                        ld_started = 1'b0;
                    end
                    if (!ld_started)
                    begin
                        first_next = {in_data.vertex_x, in_data.vertex_y};
                        prev_next  = {in_data.vertex_x, in_data.vertex_y};
                        started_next = 1'b1;
                        if (in_data.closes_path)
                        begin
                            ep_x = in_data.vertex_x;
                            ep_y = in_data.vertex_y;
                            e_do = 1'b1;
                            closed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        e_do = 1'b1;
                        prev_next = {in_data.vertex_x, in_data.vertex_y};
                        if (in_data.closes_path)
                            state_next = S_CLOSE;
                    end
                    cnt_next = ld_cnt;
                    per_next = ld_per;
                    if (e_do)
                    begin
                        if (e_diag)
                            bad_next = 1'b1;
                        else if (ld_cnt < CMAX)
                        begin
                            cnt_next = ld_cnt + CW'(1);
                            per_next = ld_per + elen;
                        end
                    end
                end
                else if (accept)
                begin
                    if (bad_reg)
                    begin
                        ov_next = 1'b1;
                        od_next = '{status: ST_BAD, pos_x: '0, pos_y: '0};
                    end
                    else if (!closed_reg || cnt_reg == '0)
                    begin
                        ov_next = 1'b1;
                        od_next = '{status: ST_NO_PATH, pos_x: '0, pos_y: '0};
                    end
                    else
                    begin
                        q_next = in_data.query_time;
                        if (per_reg == '0)
                        begin
                            t_next = '0;
                            lo_next = '0;
                            hi_next = cnt_reg - CW'(1);
                            state_next = S_SRCH;
                        end
                        else
                            state_next = S_DIV;
                    end
                end
            end
            S_CLOSE:
            begin
                ep_x = prev_reg[31:16];
                ep_y = prev_reg[15:0];
                eq_x = first_reg[31:16];
                eq_y = first_reg[15:0];
                e_do = 1'b1;
                closed_next = 1'b1;
                state_next  = S_IDLE;
                if (e_diag)
                    bad_next = 1'b1;
                else if (cnt_reg < CMAX)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    per_next = per_reg + elen;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next  = div_rem;
                    lo_next = '0;
                    hi_next = cnt_reg - CW'(1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_reg + (span >> 1);
                    state_next = S_WAIT;
                end
                else
                begin
                    mid_next   = lo_reg;
                    state_next = S_FETCH;
                end
            end
            S_WAIT:
            begin
                if (rdata.stime <= t_reg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg - CW'(1);
                state_next = S_SRCH;
            end
            S_FETCH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // The edge read stays put while an older result is still stalled.
                if (!(ov_reg && out_stall))
                begin
                    ov_next = 1'b1;
                    od_next = '{status: ST_OK, pos_x: px, pos_y: py};
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // The memory address follows the next search index so the data arrives with the registered index.
        raddr = mid_next[AW-1:0];
    end

    // The divider is kicked on entry to the modulo state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_kick_reg <= 1'b0;
        else
            div_kick_reg <= (state_next == S_DIV) && (state_reg != S_DIV);
    end

    assign div_start = div_kick_reg;

    assign we    = e_do && !e_diag && (ld_cnt < CMAX);
    assign waddr = ld_cnt[AW-1:0];
    assign wdata = '{sx: ep_x, sy: ep_y, heading: eh, stime: ld_per};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            per_reg     <= '0;
            first_reg   <= '0;
            prev_reg    <= '0;
            closed_reg  <= 1'b0;
            bad_reg     <= 1'b0;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            per_reg     <= per_next;
            first_reg   <= first_next;
            prev_reg    <= prev_next;
            closed_reg  <= closed_next;
            bad_reg     <= bad_next;
            started_reg <= started_next;
            ov_reg      <= ov_next || (ov_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        t_reg   <= t_next;
        q_reg   <= q_next;
        if (!(ov_reg && out_stall))
            od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_div_kick: assert property (@(posedge clk) disable iff (!rst_n)
        div_kick_reg |-> state_reg == S_DIV)
        else $error("divider kicked outside modulo state");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item taken while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CMAX)
        else $error("edge count beyond table");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
endmodule

@@ rtl/core/cpp_divu.sv @@
module cpp_divu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    // Restoring remainder, one quotient bit per cycle.
    logic [32:0] rem_reg, rem_next;
    logic [30:0] num_reg, num_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], num_reg[30]};
        if (start)
        begin
            rem_next  = '0;
            num_next  = dividend;
            cnt_next  = 5'd30;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = trial - {1'b0, divisor};
            else
                rem_next = trial;
            num_next = {num_reg[29:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];
endmodule

@@ rtl/core/cpp_edge_mem.sv @@
module cpp_edge_mem #(
    parameter int AW = 10
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  cpp_pkg::edge_t       wdata,
    input  logic [AW-1:0]        raddr,
    output cpp_pkg::edge_t       rdata
);
    import cpp_pkg::*;

    edge_t mem [1 << AW];
    edge_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ bench/testbench.sv @@
module testbench;
    import cpp_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int RANDOM_ITEMS = 600;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    closed_path_position_at_time u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predictor state for the path.
    logic signed [15:0] pth_sx [TABLE_DEPTH];
    logic signed [15:0] pth_sy [TABLE_DEPTH];
    logic [1:0] pth_head [TABLE_DEPTH];
    logic [31:0] pth_stime [TABLE_DEPTH];
    int unsigned pth_count;
    logic [31:0] pth_perimeter;
    logic signed [15:0] first_x, first_y, prev_x, prev_y;
    bit pth_closed, pth_bad, pth_started;

    out_item_t expected_positions[$];
    int mismatches;
    bit stimulus_done;
    bit hold_off;

    // Typed-in result that travels with the directed beat being offered.
    bit row_check;
    out_item_t row_want;

    function automatic void path_reset();
        pth_count = 0;
        pth_perimeter = 0;
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        pth_closed = 0; pth_bad = 0; pth_started = 0;
    endfunction

    function automatic void add_edge(input logic signed [15:0] px, input logic signed [15:0] py,
                                     input logic signed [15:0] qx, input logic signed [15:0] qy);
        int d;
        logic [1:0] h;
        if (px == qx) begin
            d = int'(qy) - int'(py);
            h = (d > 0) ? HD_UP : HD_DOWN;
        end
        else if (py == qy) begin
            d = int'(qx) - int'(px);
            h = (d > 0) ? HD_RIGHT : HD_LEFT;
        end
        else begin
            pth_bad = 1;
            return;
        end
        if (pth_count >= TABLE_DEPTH)
            return;
        pth_sx[pth_count] = px;
        pth_sy[pth_count] = py;
        pth_head[pth_count] = h;
        pth_stime[pth_count] = pth_perimeter;
        pth_count++;
        pth_perimeter += (d > 0) ? d : -d;
    endfunction

    // Advances the path model by one beat; returns 1 and a result for queries.
    function automatic bit predict_position(input in_item_t it, output out_item_t res);
        logic [31:0] t, diff;
        int unsigned lo, hi, mid;
        logic [31:0] px, py;
        res = '0;
        if (it.operation == OP_LOAD) begin
            if (pth_closed)
                path_reset();
            if (!pth_started) begin
                first_x = it.vertex_x; first_y = it.vertex_y;
                prev_x = it.vertex_x; prev_y = it.vertex_y;
                pth_started = 1;
                if (it.closes_path) begin
                    add_edge(it.vertex_x, it.vertex_y, it.vertex_x, it.vertex_y);
                    pth_closed = 1;
                end
            end
            else begin
                add_edge(prev_x, prev_y, it.vertex_x, it.vertex_y);
                prev_x = it.vertex_x; prev_y = it.vertex_y;
                if (it.closes_path) begin
                    add_edge(it.vertex_x, it.vertex_y, first_x, first_y);
                    pth_closed = 1;
                end
            end
            return 0;
        end
        if (pth_bad) begin
            res.status = ST_BAD;
            return 1;
        end
        if (!pth_closed || pth_count == 0) begin
            res.status = ST_NO_PATH;
            return 1;
        end
        t = (pth_perimeter != 0) ? {1'b0, it.query_time} % pth_perimeter : 32'd0;
        lo = 0;
        hi = pth_count - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (pth_stime[mid] <= t)
                lo = mid;
            else
                hi = mid - 1;
        end
        diff = t - pth_stime[lo];
        px = {{16{pth_sx[lo][15]}}, pth_sx[lo]};
        py = {{16{pth_sy[lo][15]}}, pth_sy[lo]};
        case (pth_head[lo])
            HD_UP:    py = py + diff;
            HD_DOWN:  py = py - diff;
            HD_RIGHT: px = px + diff;
            default:  px = px - diff;
        endcase
        res.status = ST_OK;
        res.pos_x = px[15:0];
        res.pos_y = py[15:0];
        return 1;
    endfunction

    // Directed rows; check_now marks rows whose result is typed in.
    typedef struct {
        in_item_t item;
        bit check_now;
        out_item_t want;
    } row_t;
    row_t directed_rows[$];

    function automatic in_item_t load_item(input int x, input int y, input bit last);
        in_item_t it;
        it = '0;
        it.operation = OP_LOAD;
        it.vertex_x = x[15:0];
        it.vertex_y = y[15:0];
        it.closes_path = last;
        it.query_time = 31'($urandom);
        return it;
    endfunction

    function automatic in_item_t query_item(input logic [30:0] qt);
        in_item_t it;
        it = '0;
        it.operation = OP_QUERY;
        it.vertex_x = 16'($urandom);
        it.vertex_y = 16'($urandom);
        it.closes_path = 1'($urandom_range(0, 1));
        it.query_time = qt;
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit chk, input logic [1:0] st,
                                    input int x, input int y);
        row_t r;
        r.item = it;
        r.check_now = chk;
        r.want.status = st;
        r.want.pos_x = x[15:0];
        r.want.pos_y = y[15:0];
        directed_rows = {directed_rows, r};
    endfunction

    function automatic void build_directed();
        // Nothing loaded yet.
        add_row(query_item(31'h7FFF_FFFF), 1, ST_NO_PATH, 0, 0);
        // Extreme square, including a zero-length edge.
        add_row(load_item(-32768, -32768, 0), 0, ST_OK, 0, 0);
        add_row(load_item(-32768, -32768, 0), 0, ST_OK, 0, 0);
        add_row(query_item(0), 1, ST_NO_PATH, 0, 0);
        add_row(load_item(32767, -32768, 0), 0, ST_OK, 0, 0);
        add_row(load_item(32767, 32767, 0), 0, ST_OK, 0, 0);
        add_row(load_item(-32768, 32767, 1), 0, ST_OK, 0, 0);
        add_row(query_item(0), 1, ST_OK, -32768, -32768);
        add_row(query_item(65535), 1, ST_OK, 32767, -32768);
        add_row(query_item(31'h7FFF_FFFF), 0, ST_OK, 0, 0);
        add_row(query_item(200000), 0, ST_OK, 0, 0);
        // Single-vertex path: zero perimeter.
        add_row(load_item(5, -7, 1), 0, ST_OK, 0, 0);
        add_row(query_item(12345), 1, ST_OK, 5, -7);
        // Diagonal edge sets the error.
        add_row(load_item(0, 0, 0), 0, ST_OK, 0, 0);
        add_row(load_item(3, 4, 0), 0, ST_OK, 0, 0);
        add_row(query_item(1), 1, ST_BAD, 0, 0);
        add_row(load_item(3, 0, 1), 0, ST_OK, 0, 0);
        add_row(query_item(2), 1, ST_BAD, 0, 0);
        // New path clears the error.
        add_row(load_item(10, 10, 0), 0, ST_OK, 0, 0);
        add_row(load_item(10, 20, 1), 0, ST_OK, 0, 0);
        add_row(query_item(15), 1, ST_OK, 10, 15);
        add_row(query_item(31'h4000_0001), 0, ST_OK, 0, 0);
    endfunction

    // Sender: bursts with random gaps.
    in_item_t send_queue[$];
    int burst_left;

    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Predictions are made at acceptance so they follow the order of beats.
    always @(posedge clk) begin
        out_item_t r;
        if (rst_n && in_valid && !in_stall)
            if (predict_position(in_data, r))
                expected_positions = {expected_positions, row_check ? row_want : r};
    end

    // Checker.
    always @(posedge clk) begin
        out_item_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", out_data);
            end
            else begin
                w = expected_positions.pop_front();
                if (out_data.status !== w.status || out_data.pos_x !== w.pos_x
                        || out_data.pos_y !== w.pos_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected status %0d x %0d y %0d, got %0d %0d %0d",
                                 w.status, w.pos_x, w.pos_y,
                                 out_data.status, out_data.pos_x, out_data.pos_y);
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off.
    int stall_phase = 0;
    always @(posedge clk) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8])
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (800) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(0, 200) - 100;
        endcase
    endfunction

    function automatic logic [30:0] pick_time();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return 31'(31'h7FFF_FFFF - $urandom_range(0, 3));
            default: return 31'($urandom_range(0, 3000));
        endcase
    endfunction

    // Builds one random path of axis-aligned moves, now and then broken.
    task automatic make_path();
        int n, x, y, step;
        bit broken;
        n = ($urandom_range(0, 30) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        x = pick_coord();
        y = pick_coord();
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                step = $urandom_range(0, 400) - 200;
                if (broken && $urandom_range(0, 3) == 0) begin
                    x += step; y += $urandom_range(1, 50);
                end
                else if ($urandom_range(0, 1))
                    x += step;
                else
                    y += step;
                if ($urandom_range(0, 15) == 0)
                    x = pick_coord();
            end
            send_queue = {send_queue, load_item(x, y, i == n - 1)};
        end
        repeat ($urandom_range(1, 8))
            send_queue = {send_queue, query_item(pick_time())};
    endtask

    initial begin
        int sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        stimulus_done = 0;
        burst_left = 0;
        row_check = 1'b0;
        row_want = '0;
        path_reset();
        build_directed();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i]) begin
            row_check <= directed_rows[i].check_now;
            row_want <= directed_rows[i].want;
            send_item(directed_rows[i].item);
        end
        row_check <= 1'b0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                send_queue = {send_queue, query_item(pick_time())};
            else
                make_path();
            while (send_queue.size() > 0) begin
                send_item(send_queue.pop_front());
                sent++;
            end
        end
        in_valid <= 1'b0;
        while (expected_positions.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_positions.size() == 0)
            $display("closed_path_position_at_time regression: pass");
        else
            $display("closed_path_position_at_time regression: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("closed_path_position_at_time regression: fail");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/cpp_pkg.sv
rtl/core/cpp_divu.sv
rtl/core/cpp_edge_mem.sv
rtl/core/closed_path_position_at_time.sv
bench/testbench.sv
